// ===== src/ifmt_pkg.sv =====
`timescale 1ns / 1ps
package ifmt_pkg;

    // Conversion codes as they arrive on the request.
    localparam logic [3:0] MODE_D   = 4'd0;
    localparam logic [3:0] MODE_U   = 4'd1;
    localparam logic [3:0] MODE_O   = 4'd2;
    localparam logic [3:0] MODE_X   = 4'd3;
    localparam logic [3:0] MODE_XU  = 4'd4;
    localparam logic [3:0] MODE_P   = 4'd5;
    localparam logic [3:0] MODE_C   = 4'd6;
    localparam logic [3:0] MODE_PCT = 4'd7;

    localparam logic [1:0] SZ_INT   = 2'd0;
    localparam logic [1:0] SZ_SHORT = 2'd1;
    localparam logic [1:0] SZ_CHAR  = 2'd2;
    localparam logic [1:0] SZ_LONG  = 2'd3;

    // Job kinds seen by the back end.
    localparam logic [1:0] KIND_RAW = 2'd0;
    localparam logic [1:0] KIND_DEC = 2'd1;
    localparam logic [1:0] KIND_OCT = 2'd2;
    localparam logic [1:0] KIND_HEX = 2'd3;

    localparam int MAX_WIDTH = 64;
    localparam int CNT_W     = 7;
    localparam int DIG_N     = 22;
    localparam int DIG_W     = 5;
    localparam int Q_DEPTH   = 2;
    localparam int PTR_DIGS  = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] value;
        logic [1:0]  size_sel;
        logic        flag_left;
        logic        flag_zero;
        logic        flag_plus;
        logic        flag_space;
        logic        flag_hash;
        logic [6:0]  width;
    } ifmt_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ifmt_res_t;

    // One classified conversion waiting for the back end.
    typedef struct packed {
        logic [1:0]       kind;
        logic             upper;
        logic [63:0]      mag;
        logic [7:0]       pre0;
        logic [7:0]       pre1;
        logic [1:0]       plen;
        logic             raw_len;
        logic [DIG_W-1:0] dlen_min;
        logic             left;
        logic             zeros;
        logic [CNT_W-1:0] width;
    } ifmt_job_t;

    typedef struct packed {
        logic idle;
        logic emitting;
    } ifmt_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = CH_ZERO + {4'd0, nib};
        end
        else if (upper)
        begin
            c = 8'h41 + {4'd0, nib} - 8'd10;
        end
        else
        begin
            c = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== src/integer_field_formatter.sv =====
`timescale 1ns / 1ps
// Channel    Ports                    Handshake
// request    req (ifmt_req_t)         taken when start is high and busy is low
// result     res (ifmt_res_t)         one character per cycle while strobe is high
//
// A request is classified as it is taken and waits in a two-entry queue.
// Hex, octal, pointer, char, percent and unknown jobs go from the queue through a length step
// into emission; decimal jobs first pass through the shift-and-add-3 BCD converter.
// One character leaves per cycle, up to 64 per request, and the back end takes the next
// job from the queue only once it has emitted the last character of the current one.
// Reset empties the queue and idles the back end. The receiver cannot stall.
module integer_field_formatter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ifmt_pkg::ifmt_req_t req,
    output logic                strobe,
    output ifmt_pkg::ifmt_res_t res
);

    ifmt_pkg::ifmt_job_t  new_job;
    ifmt_pkg::ifmt_job_t  q_data;
    ifmt_pkg::ifmt_stat_t stat;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;

    ifmt_front u_front (
        .start  (start),
        .req    (req),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .job    (new_job)
    );

    ifmt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (new_job),
        .pop     (pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    ifmt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .pop     (pop),
        .strobe  (strobe),
        .res     (res),
        .stat    (stat)
    );

    // A transaction taken from the request side is always held somewhere afterwards.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_empty)
        else $error("accepted transaction not queued");

    // A waiting job is picked up by an idle back end at once.
    a_back_pulls: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && stat.idle) |=> !stat.idle)
        else $error("back end ignored a queued job");

    // Characters of two conversions never run together.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && res.last) |=> !strobe)
        else $error("no gap after final character");

    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(stat.emitting))
        else $error("strobe without emission");

endmodule

// ===== src/ifmt_front.sv =====
`timescale 1ns / 1ps
module ifmt_front (
    input  logic                start,
    input  ifmt_pkg::ifmt_req_t req,
    input  logic                q_full,
    output logic                busy,
    output logic                push,
    output ifmt_pkg::ifmt_job_t job
);

    logic [63:0]               narrow;
    logic [63:0]               sext;
    logic                      neg;
    logic                      nz;
    logic [ifmt_pkg::CNT_W-1:0] wclip;

    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        unique case (req.size_sel)
            ifmt_pkg::SZ_INT:
            begin
                narrow = {32'd0, req.value[31:0]};
                sext   = {{32{req.value[31]}}, req.value[31:0]};
                neg    = req.value[31];
            end
            ifmt_pkg::SZ_SHORT:
            begin
                narrow = {48'd0, req.value[15:0]};
                sext   = {{48{req.value[15]}}, req.value[15:0]};
                neg    = req.value[15];
            end
            ifmt_pkg::SZ_CHAR:
            begin
                narrow = {56'd0, req.value[7:0]};
                sext   = {{56{req.value[7]}}, req.value[7:0]};
                neg    = req.value[7];
            end
            default:
            begin
                narrow = req.value;
                sext   = req.value;
                neg    = req.value[63];
            end
        endcase
        nz = (narrow != 64'd0);
        wclip = (req.width > ifmt_pkg::CNT_W'(ifmt_pkg::MAX_WIDTH)) ?
                ifmt_pkg::CNT_W'(ifmt_pkg::MAX_WIDTH) : req.width;

        job.kind     = ifmt_pkg::KIND_RAW;
        job.upper    = 1'b0;
        job.mag      = narrow;
        job.pre0     = ifmt_pkg::CH_ZERO;
        job.pre1     = ifmt_pkg::CH_X;
        job.plen     = 2'd0;
        job.raw_len  = 1'b0;
        job.dlen_min = ifmt_pkg::DIG_W'(1);
        job.left     = req.flag_left;
        job.zeros    = req.flag_zero && !req.flag_left;
        job.width    = wclip;

        unique case (req.mode) inside
            ifmt_pkg::MODE_D:
            begin
                job.kind = ifmt_pkg::KIND_DEC;
                if (neg)
                begin
                    job.mag  = 64'd0 - sext;
                    job.pre0 = ifmt_pkg::CH_MINUS;
                    job.plen = 2'd1;
                end
                else if (req.flag_plus)
                begin
                    job.pre0 = ifmt_pkg::CH_PLUS;
                    job.plen = 2'd1;
                end
                else if (req.flag_space)
                begin
                    job.pre0 = ifmt_pkg::CH_SPACE;
                    job.plen = 2'd1;
                end
            end
            ifmt_pkg::MODE_U:
            begin
                job.kind = ifmt_pkg::KIND_DEC;
            end
            ifmt_pkg::MODE_O:
            begin
                job.kind = ifmt_pkg::KIND_OCT;
                if (req.flag_hash && nz)
                begin
                    job.plen = 2'd1;
                end
            end
            ifmt_pkg::MODE_X, ifmt_pkg::MODE_XU:
            begin
                job.kind  = ifmt_pkg::KIND_HEX;
                job.upper = (req.mode == ifmt_pkg::MODE_XU);
                job.pre1  = (req.mode == ifmt_pkg::MODE_XU) ? ifmt_pkg::CH_XU : ifmt_pkg::CH_X;
                if (req.flag_hash && nz)
                begin
                    job.plen = 2'd2;
                end
            end
            ifmt_pkg::MODE_P:
            begin
                // Pointers always show the full word as sixteen lower-case digits.
                job.kind     = ifmt_pkg::KIND_HEX;
                job.mag      = req.value;
                job.plen     = 2'd2;
                job.dlen_min = ifmt_pkg::DIG_W'(ifmt_pkg::PTR_DIGS);
                job.zeros    = 1'b0;
            end
            ifmt_pkg::MODE_C:
            begin
                job.mag     = req.value;
                job.raw_len = 1'b1;
                job.zeros   = 1'b0;
            end
            ifmt_pkg::MODE_PCT:
            begin
                job.pre0  = ifmt_pkg::CH_PCT;
                job.plen  = 2'd1;
                job.left  = 1'b0;
                job.zeros = 1'b0;
                job.width = '0;
            end
            default:
            begin
                // Unknown conversion: echo it, dropping a null character.
                job.mag     = req.value;
                job.pre0    = ifmt_pkg::CH_PCT;
                job.plen    = 2'd1;
                job.raw_len = (req.value[7:0] != 8'd0);
                job.left    = 1'b0;
                job.zeros   = 1'b0;
                job.width   = '0;
            end
        endcase
    end

endmodule

// ===== src/ifmt_queue.sv =====
`timescale 1ns / 1ps
module ifmt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ifmt_pkg::ifmt_job_t wr_data,
    input  logic                pop,
    output ifmt_pkg::ifmt_job_t rd_data,
    output logic                full,
    output logic                empty
);

    localparam int PW = $clog2(ifmt_pkg::Q_DEPTH);

    ifmt_pkg::ifmt_job_t mem_reg [ifmt_pkg::Q_DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW-1:0]       rd_ptr_next;
    logic [PW:0]         count_reg;
    logic [PW:0]         count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (PW+1)'(ifmt_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(ifmt_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(ifmt_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/ifmt_back.sv =====
`timescale 1ns / 1ps
module ifmt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  ifmt_pkg::ifmt_job_t q_data,
    output logic                pop,
    output logic                strobe,
    output ifmt_pkg::ifmt_res_t res,
    output ifmt_pkg::ifmt_stat_t stat
);

    localparam int CW = ifmt_pkg::CNT_W;
    localparam int DN = ifmt_pkg::DIG_N;
    localparam int DW = ifmt_pkg::DIG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    ifmt_pkg::ifmt_job_t job_reg;
    logic [3:0]          digs_reg [DN];
    logic [3:0]          digs_next [DN];
    logic [3:0]          adj [DN];
    logic [63:0]         bin_reg;
    logic [5:0]          cnt_reg;
    logic [CW-1:0]       b1_reg;
    logic [CW-1:0]       b2_reg;
    logic [CW-1:0]       b3_reg;
    logic [CW-1:0]       b4_reg;
    logic [CW-1:0]       total_reg;
    logic [CW-1:0]       pos_reg;
    logic                strobe_reg;
    logic [7:0]          ch_reg;
    logic                last_reg;

    logic [87:0]         hex_ext;
    logic [65:0]         oct_ext;
    logic [DW-1:0]       nat_len;
    logic [DW-1:0]       dlen_calc;
    logic [CW-1:0]       body;
    logic [CW-1:0]       pad;
    logic [CW-1:0]       b1_calc;
    logic [CW-1:0]       b2_calc;
    logic [CW-1:0]       b3_calc;
    logic [CW-1:0]       b4_calc;
    logic [CW-1:0]       total_calc;
    logic [CW-1:0]       dig_pos;
    logic [3:0]          dig_val;
    logic [7:0]          ch_calc;
    logic                emit_last;

    assign pop           = (state_reg == ST_IDLE) && !q_empty;
    assign strobe        = strobe_reg;
    assign res.ch        = ch_reg;
    assign res.last      = last_reg;
    assign stat.idle     = (state_reg == ST_IDLE);
    assign stat.emitting = (state_reg == ST_EMIT);

    assign hex_ext = {24'd0, q_data.mag};
    assign oct_ext = {2'd0, q_data.mag};

    // Double dabble: correct every BCD digit, then shift one binary bit in; when idle, load hex or octal digits.
    always_comb
    begin
        for (int i = 0; i < DN; i++)
        begin
            adj[i] = (digs_reg[i] >= 4'd5) ? digs_reg[i] + 4'd3 : digs_reg[i];
        end
        for (int i = 0; i < DN; i++)
        begin
            if (state_reg == ST_IDLE)
            begin
                if (q_data.kind == ifmt_pkg::KIND_HEX)
                begin
                    digs_next[i] = hex_ext[4*i +: 4];
                end
                else if (q_data.kind == ifmt_pkg::KIND_OCT)
                begin
                    digs_next[i] = {1'b0, oct_ext[3*i +: 3]};
                end
                else
                begin
                    digs_next[i] = 4'd0;
                end
            end
            else if (i == 0)
            begin
                digs_next[i] = {adj[0][2:0], bin_reg[63]};
            end
            else
            begin
                digs_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end
    end

    always_comb
    begin
        nat_len = DW'(1);
        for (int i = 1; i < DN; i++)
        begin
            if (digs_reg[i] != 4'd0)
            begin
                nat_len = DW'(i + 1);
            end
        end
        if (job_reg.kind == ifmt_pkg::KIND_RAW)
        begin
            dlen_calc = DW'(job_reg.raw_len);
        end
        else if (nat_len < job_reg.dlen_min)
        begin
            dlen_calc = job_reg.dlen_min;
        end
        else
        begin
            dlen_calc = nat_len;
        end
        body       = CW'(job_reg.plen) + CW'(dlen_calc);
        pad        = (job_reg.width > body) ? job_reg.width - body : '0;
        b1_calc    = (!job_reg.left && !job_reg.zeros) ? pad : '0;
        b2_calc    = b1_calc + CW'(job_reg.plen);
        b3_calc    = b2_calc + ((!job_reg.left && job_reg.zeros) ? pad : '0);
        b4_calc    = b3_calc + CW'(dlen_calc);
        total_calc = b4_calc + (job_reg.left ? pad : '0);
    end

    always_comb
    begin
        dig_pos = b4_reg - CW'(1) - pos_reg;
        dig_val = (dig_pos < CW'(DN)) ? digs_reg[dig_pos[DW-1:0]] : 4'd0;
        if (pos_reg < b1_reg)
        begin
            ch_calc = ifmt_pkg::CH_SPACE;
        end
        else if (pos_reg < b2_reg)
        begin
            ch_calc = (pos_reg == b1_reg) ? job_reg.pre0 : job_reg.pre1;
        end
        else if (pos_reg < b3_reg)
        begin
            ch_calc = ifmt_pkg::CH_ZERO;
        end
        else if (pos_reg < b4_reg)
        begin
            ch_calc = (job_reg.kind == ifmt_pkg::KIND_RAW) ? job_reg.mag[7:0] :
                      ifmt_pkg::hex_char(dig_val, job_reg.upper);
        end
        else
        begin
            ch_calc = ifmt_pkg::CH_SPACE;
        end
        emit_last = (pos_reg == total_reg - CW'(1));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_data.kind == ifmt_pkg::KIND_DEC) ? ST_CONV : ST_LEN;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_EMIT);
            if (state_reg == ST_CONV)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_calc;
        last_reg <= emit_last;
        if (pop)
        begin
            job_reg <= q_data;
            bin_reg <= q_data.mag;
        end
        else if (state_reg == ST_CONV)
        begin
            bin_reg <= {bin_reg[62:0], 1'b0};
        end
        if (pop || state_reg == ST_CONV)
        begin
            for (int i = 0; i < DN; i++)
            begin
                digs_reg[i] <= digs_next[i];
            end
        end
        if (state_reg == ST_LEN)
        begin
            b1_reg    <= b1_calc;
            b2_reg    <= b2_calc;
            b3_reg    <= b3_calc;
            b4_reg    <= b4_calc;
            total_reg <= total_calc;
            pos_reg   <= '0;
        end
        else if (state_reg == ST_EMIT)
        begin
            pos_reg <= pos_reg + CW'(1);
        end
    end

endmodule
